### hw/rtl/tccs_pkg.sv
// Shared constants for the text console cursor and scroll block.
`default_nettype none
package tccs_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam int TAB_STEP = 4;

    typedef logic [15:0] cell_t;

endpackage
`default_nettype wire

### hw/rtl/text_console_cursor_scroll_top.sv
// Text console screen store with cursor, scroll-up, cell read and clear.
// Put without scroll: result in the cycle after accept. Read: cell into the read register, then the result.
// Put with scroll: copy one cell a cycle up one line, then blank the last line,
// bound by the single read and single write port of the screen memory.
// Clear: one cell written per cycle.
// After reset a pass fills the screen with blanks; no item is taken until done.
`default_nettype none
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       attr_wr_en,
    input  wire logic [7:0] attr_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] char_code,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_attr,
    output logic [6:0]      cursor_col,
    output logic [4:0]      cursor_row,
    output logic            scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] COL_A       = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BLANK_START = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [COL_W:0]    COL_END     = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]    TAB_ADV     = (COL_W + 1)'(TAB_STEP);
    localparam logic [ROW_W:0]    ROW_END     = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;
    localparam logic [2:0] ST_INIT  = 3'd6;

    cell_t mem [CELLS];
    cell_t mem_rdata_reg;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        attr_reg, attr_next;
    logic              copy_pend_reg, copy_pend_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, attr_out_reg;
    logic [6:0]        ccol_reg;
    logic [4:0]        crow_reg;
    logic              scroll_reg;

    logic              accept;
    logic [ADDR_W-1:0] cur_addr, rd_addr;
    logic [COL_W:0]    col_adv;
    logic [ROW_W:0]    row_adv;
    logic              put_scroll, put_store;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    cell_t             mem_wdata;
    logic              load;
    logic [7:0]        ld_char, ld_attr;
    logic              ld_scroll;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign cur_addr = ADDR_W'(row_reg) * COL_A + ADDR_W'(col_reg);
    assign rd_addr  = ADDR_W'(read_row) * COL_A + ADDR_W'(read_col);

    // cursor advance for a put
    always_comb
    begin
        put_store = 1'b0;
        unique case (char_code)
            CH_NEWLINE:
            begin
                col_adv = '0;
                row_adv = {1'b0, row_reg} + 1'b1;
            end
            CH_RETURN:
            begin
                col_adv = '0;
                row_adv = {1'b0, row_reg};
            end
            CH_TAB:
            begin
                col_adv = {1'b0, col_reg} + TAB_ADV;
                row_adv = {1'b0, row_reg};
            end
            default:
            begin
                put_store = 1'b1;
                col_adv   = {1'b0, col_reg} + 1'b1;
                row_adv   = {1'b0, row_reg};
            end
        endcase
        if (col_adv >= COL_END)
        begin
            col_adv = '0;
            row_adv = row_adv + 1'b1;
        end
        put_scroll = (row_adv >= ROW_END);
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = attr_wr_en ? attr_wr_data : attr_reg;
        copy_pend_next = (state_reg == ST_COPY);
        copy_addr_next = ptr_reg - COL_A;
        rd_ok_next     = rd_ok_reg;
        load           = 1'b0;
        ld_char        = '0;
        ld_attr        = '0;
        ld_scroll      = 1'b0;
        mem_raddr      = ptr_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = {attr_reg, CH_SPACE};

        if (copy_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = mem_rdata_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = rd_addr;
                if (accept)
                begin
                    unique case (operation)
                        OP_PUT:
                        begin
                            if (put_store)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {attr_reg, char_code};
                            end
                            col_next = col_adv[COL_W-1:0];
                            if (put_scroll)
                            begin
                                row_next   = ROW_LAST;
                                ptr_next   = COL_A;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                row_next = row_adv[ROW_W-1:0];
                                load     = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            rd_ok_next = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load       = 1'b1;
                ld_char    = rd_ok_reg ? mem_rdata_reg[7:0] : 8'h00;
                ld_attr    = rd_ok_reg ? mem_rdata_reg[15:8] : 8'h00;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                ptr_next   = BLANK_START;
                state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    load       = 1'b1;
                    ld_scroll  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, CH_SPACE};
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= RESET_ATTR;
            copy_pend_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            copy_pend_reg <= copy_pend_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        if (load)
        begin
            char_reg     <= ld_char;
            attr_out_reg <= ld_attr;
            ccol_reg     <= 7'(col_next);
            crow_reg     <= 5'(row_next);
            scroll_reg   <= ld_scroll;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = char_reg;
    assign cell_attr  = attr_out_reg;
    assign cursor_col = ccol_reg;
    assign cursor_row = crow_reg;
    assign scrolled   = scroll_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scrolled) |-> (cursor_row == 5'(ROWS - 1) && cursor_col == '0))
        else $error("scroll result without cursor on last row");

    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY || state_reg == ST_BLANK || state_reg == ST_CLEAR)
            |-> !out_valid_reg)
        else $error("result shown during screen sweep");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_CLEAR) |=> (col_reg == '0 && row_reg == '0))
        else $error("clear did not home cursor");

endmodule
`default_nettype wire
